// ----- design/lsvb_pkg.sv -----
`default_nettype none
package lsvb_pkg;

   localparam int VOICES_DEFAULT           = 8;
   localparam int PHASE_BITS_DEFAULT       = 24;
   localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

   localparam int NOTE_BITS  = 7;
   localparam int PITCH_BITS = 8;
   localparam int SCALE_BITS = 26;
   localparam int FREQ_BITS  = 25;
   localparam int OCT_BITS   = 4;
   localparam int SAMPLE_BITS = 16;
   localparam int ENV_BITS   = 16;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 26'd6233059;

   localparam int PITCH_TOP        = 144;
   localparam int NOTES_PER_OCTAVE = 12;
   localparam int DIV12_RECIP      = 171;
   localparam int DIV12_SHIFT      = 11;
   localparam int STEP_TOP         = 48;

   localparam int ENV_RISE  = 66;
   localparam int ENV_FULL  = 32768;
   localparam int Q15_ONE   = 32768;
   localparam int Q15_MAX   = 32767;
   localparam int POLY_C0   = 51472;
   localparam int POLY_C1   = 21024;
   localparam int POLY_C2   = 2320;
   localparam int MIX_GAIN  = 3277;
   localparam int ROUND_SHIFT = 30;

   localparam logic CMD_NOTE_ON = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef struct packed {
      logic note_on;
      logic acc_clear;
      logic issue;
      logic load_out;
   } lsvb_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } lsvb_status_type;

   function automatic logic [FREQ_BITS-1:0] top_octave_q10(input logic [OCT_BITS-1:0] semi);
      logic [FREQ_BITS-1:0] f;
      case (semi)
         4'd0:    f = 25'd14417920;
         4'd1:    f = 25'd15275254;
         4'd2:    f = 25'd16183568;
         4'd3:    f = 25'd17145893;
         4'd4:    f = 25'd18165441;
         4'd5:    f = 25'd19245614;
         4'd6:    f = 25'd20390018;
         4'd7:    f = 25'd21602472;
         4'd8:    f = 25'd22887022;
         4'd9:    f = 25'd24247955;
         4'd10:   f = 25'd25689813;
         4'd11:   f = 25'd27217408;
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

// ----- design/layered_sine_voice_bank.sv -----
`default_nettype none
// Bank of VOICES sine voices mixed to one saturated Q0.15 mono sample. A note-on word
// (cmd 0) retunes voice i to note_number + i, clears its phase and envelope and
// activates it; it returns nothing. A tick word (cmd 1) returns one sample: the voices
// go one per cycle into a ten-stage pipeline (pitch lookup, frequency lookup, phase
// step multiply, phase and envelope update, quadrant fold and z squared, three
// polynomial sine multiplies, envelope and gain multiplies) feeding one accumulator,
// followed by rounding and saturation into the output register. The step scale
// written through csr_write_data takes effect on the next tick.
module layered_sine_voice_bank
   import lsvb_pkg::*;
#(
   parameter int VOICES           = VOICES_DEFAULT,
   parameter int PHASE_BITS       = PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_cmd,
   input  wire logic [NOTE_BITS-1:0]     req_note_number,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  wire logic                     csr_write_enable,
   input  wire logic [SCALE_BITS-1:0]    csr_write_data
);

   localparam int VIDX_BITS = (VOICES > 1) ? $clog2(VOICES) : 1;

   lsvb_cmd_type          cmd;
   lsvb_status_type       status;
   logic [VIDX_BITS-1:0]  vidx;

   lsvb_ctrl #(
      .VOICES    (VOICES),
      .VIDX_BITS (VIDX_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .vidx      (vidx),
      .status    (status)
   );

   lsvb_datapath #(
      .VOICES           (VOICES),
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .VIDX_BITS        (VIDX_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .vidx             (vidx),
      .status           (status),
      .note_number      (req_note_number),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .sample_out       (rsp_sample_out)
   );

endmodule
`default_nettype wire

// ----- design/lsvb_ctrl.sv -----
`default_nettype none
module lsvb_ctrl
   import lsvb_pkg::*;
#(
   parameter int VOICES    = VOICES_DEFAULT,
   parameter int VIDX_BITS = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output lsvb_cmd_type              cmd,
   output logic [VIDX_BITS-1:0]      vidx,
   input  wire lsvb_status_type      status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [VIDX_BITS-1:0]  vcnt_ff, vcnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign vidx      = vcnt_ff;

   always_comb begin
      state_in     = state_ff;
      vcnt_in      = vcnt_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_NOTE_ON) begin
                  cmd.note_on = 1'b1;
               end else begin
                  cmd.acc_clear = 1'b1;
                  vcnt_in       = '0;
                  state_in      = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (vcnt_ff == VIDX_BITS'(VOICES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               vcnt_in = vcnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/lsvb_datapath.sv -----
`default_nettype none
module lsvb_datapath
   import lsvb_pkg::*;
#(
   parameter int VOICES           = VOICES_DEFAULT,
   parameter int PHASE_BITS       = PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT,
   parameter int VIDX_BITS        = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lsvb_cmd_type             cmd,
   input  wire logic [VIDX_BITS-1:0]     vidx,
   output lsvb_status_type               status,
   input  wire logic [NOTE_BITS-1:0]     note_number,
   input  wire logic                     csr_write_enable,
   input  wire logic [SCALE_BITS-1:0]    csr_write_data,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   localparam int STAGES    = 10;
   localparam int PT_BITS   = $clog2(SINE_TABLE_DEPTH);
   localparam int PROD_BITS = FREQ_BITS + SCALE_BITS;
   localparam int SE_BITS   = 33;
   localparam int MIX_BITS  = 46;
   localparam int ACC_BITS  = MIX_BITS + $clog2(VOICES);
   localparam int Q_BITS    = ACC_BITS - ROUND_SHIFT;
   localparam logic signed [ACC_BITS-1:0] ROUND_UP   = ACC_BITS'(64'd1 << (ROUND_SHIFT - 1));
   localparam logic signed [ACC_BITS-1:0] ROUND_DOWN = ACC_BITS'((64'd1 << (ROUND_SHIFT - 1)) - 1);
   localparam logic signed [Q_BITS-1:0]   SAT_HI     = Q_BITS'(32767);
   localparam logic signed [Q_BITS-1:0]   SAT_LO     = Q_BITS'(-32768);
   localparam logic signed [MIX_BITS-1:0] GAIN_S     = MIX_BITS'(MIX_GAIN);

   // voice state
   logic [PHASE_BITS-1:0] phase_ff [VOICES];
   logic [ENV_BITS-1:0]   env_ff   [VOICES];
   logic [PITCH_BITS-1:0] pitch_ff [VOICES];
   logic [VOICES-1:0]     active_ff;
   logic [SCALE_BITS-1:0] scale_ff;

   logic [STAGES-1:0]     valid_ff;

   // stage registers
   logic [VIDX_BITS-1:0]  i1_ff, i2_ff, i3_ff;
   logic                  act1_ff, act2_ff, act3_ff;
   logic [OCT_BITS-1:0]   oct1_ff, semi1_ff;
   logic [FREQ_BITS-1:0]  freq2_ff;
   logic [PROD_BITS-1:0]  prod3_ff;
   logic [PHASE_BITS-1:0] phase4_ff;
   logic [ENV_BITS-1:0]   env4_ff, env5_ff, env6_ff, env7_ff, env8_ff;
   logic [15:0]           z5_ff, z6_ff, z7_ff;
   logic [15:0]           z2_5_ff, z2_6_ff;
   logic                  neg5_ff, neg6_ff, neg7_ff;
   logic [14:0]           t1_6_ff;
   logic [15:0]           t2_7_ff;
   logic signed [SAMPLE_BITS-1:0] sine8_ff;
   logic signed [SE_BITS-1:0]     se9_ff;
   logic signed [MIX_BITS-1:0]    m10_ff;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;

   // stage 1: octave and semitone of the clamped pitch
   logic [PITCH_BITS-1:0] pitch_rd, pitch_clamp, pitch_dist;
   logic [15:0]           div_prod;
   logic [OCT_BITS-1:0]   oct_in, rem_in, semi_in;

   assign pitch_rd    = pitch_ff[vidx];
   assign pitch_clamp = (pitch_rd > PITCH_BITS'(PITCH_TOP)) ? PITCH_BITS'(PITCH_TOP) : pitch_rd;
   assign pitch_dist  = PITCH_BITS'(PITCH_TOP) - pitch_clamp;
   assign div_prod    = 16'(pitch_dist) * 16'(DIV12_RECIP);
   assign oct_in      = OCT_BITS'(div_prod >> DIV12_SHIFT);
   assign rem_in      = OCT_BITS'(pitch_dist - PITCH_BITS'(oct_in) * PITCH_BITS'(NOTES_PER_OCTAVE));
   assign semi_in     = OCT_BITS'(NOTES_PER_OCTAVE - 1) - rem_in;

   // stage 4: phase and envelope update
   logic [PHASE_BITS-1:0] phase_in;
   logic [16:0]           env_sum;
   logic [ENV_BITS-1:0]   env_in;

   assign phase_in = phase_ff[i3_ff] + prod3_ff[STEP_TOP-1 -: PHASE_BITS];
   assign env_sum  = 17'(env_ff[i3_ff]) + 17'(ENV_RISE);
   assign env_in   = (env_sum > 17'(ENV_FULL)) ? ENV_BITS'(ENV_FULL) : ENV_BITS'(env_sum);

   // stage 5: quadrant fold and z squared
   logic [PT_BITS-1:0] point;
   logic [15:0]        u_word;
   logic [14:0]        z_low;
   logic [15:0]        z_in;
   logic [31:0]        zz_prod;

   assign point   = phase4_ff[PHASE_BITS-1 -: PT_BITS];
   assign u_word  = {point, {(16 - PT_BITS){1'b0}}};
   assign z_low   = {u_word[13:0], 1'b0};
   assign z_in    = u_word[14] ? 16'(17'(Q15_ONE) - 17'(z_low)) : 16'(z_low);
   assign zz_prod = 32'(z_in) * 32'(z_in);

   // stages 6 to 8: polynomial
   logic [31:0] p1_prod, p2_prod, p3_prod;
   logic [31:0] t1_full, t2_full;
   logic [16:0] y_raw;
   logic [15:0] y_cap;

   assign p1_prod = 32'(z2_5_ff) * 32'(POLY_C2);
   assign t1_full = 32'(POLY_C1) - (p1_prod >> 15);
   assign p2_prod = 32'(z2_6_ff) * 32'(t1_6_ff);
   assign t2_full = 32'(POLY_C0) - (p2_prod >> 15);
   assign p3_prod = 32'(z7_ff) * 32'(t2_7_ff);
   assign y_raw   = 17'(p3_prod >> 15);
   assign y_cap   = (y_raw > 17'(Q15_MAX)) ? 16'(Q15_MAX) : 16'(y_raw);

   // stages 9 and 10: envelope and gain
   logic signed [SE_BITS-1:0]  sine_ext, env_ext;
   assign sine_ext = SE_BITS'(sine8_ff);
   assign env_ext  = signed'(SE_BITS'(env8_ff));

   // round half away from zero, then saturate
   logic signed [ACC_BITS-1:0] acc_biased;
   logic signed [Q_BITS-1:0]   acc_q;

   assign acc_biased = acc_ff + (acc_ff[ACC_BITS-1] ? ROUND_DOWN : ROUND_UP);
   assign acc_q      = Q_BITS'(acc_biased >>> ROUND_SHIFT);

   always_comb begin
      if (acc_q > SAT_HI) begin
         sample_in = SAMPLE_BITS'(SAT_HI);
      end else if (acc_q < SAT_LO) begin
         sample_in = SAMPLE_BITS'(SAT_LO);
      end else begin
         sample_in = SAMPLE_BITS'(acc_q);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (valid_ff[STAGES-1]) begin
         acc_in = acc_ff + ACC_BITS'(m10_ff);
      end
   end

   assign status.pipe_busy = |valid_ff;
   assign sample_out       = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         active_ff <= '0;
         scale_ff  <= SCALE_RESET;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], cmd.issue};
         if (cmd.note_on) begin
            active_ff <= '1;
         end
         if (csr_write_enable) begin
            scale_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int v = 0; v < VOICES; v++) begin
         if (reset) begin
            pitch_ff[v] <= '0;
            phase_ff[v] <= '0;
            env_ff[v]   <= '0;
         end else if (cmd.note_on) begin
            pitch_ff[v] <= PITCH_BITS'(note_number) + PITCH_BITS'(v);
            phase_ff[v] <= '0;
            env_ff[v]   <= '0;
         end else if (valid_ff[2] && act3_ff && (i3_ff == VIDX_BITS'(v))) begin
            phase_ff[v] <= phase_in;
            env_ff[v]   <= env_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      i1_ff     <= vidx;
      act1_ff   <= active_ff[vidx];
      oct1_ff   <= oct_in;
      semi1_ff  <= semi_in;

      i2_ff     <= i1_ff;
      act2_ff   <= act1_ff;
      freq2_ff  <= top_octave_q10(semi1_ff) >> oct1_ff;

      i3_ff     <= i2_ff;
      act3_ff   <= act2_ff;
      prod3_ff  <= PROD_BITS'(freq2_ff) * PROD_BITS'(scale_ff);

      phase4_ff <= phase_in;
      env4_ff   <= act3_ff ? env_in : '0;

      z5_ff     <= z_in;
      z2_5_ff   <= 16'(zz_prod >> 15);
      neg5_ff   <= u_word[15];
      env5_ff   <= env4_ff;

      t1_6_ff   <= 15'(t1_full);
      z2_6_ff   <= z2_5_ff;
      z6_ff     <= z5_ff;
      neg6_ff   <= neg5_ff;
      env6_ff   <= env5_ff;

      t2_7_ff   <= 16'(t2_full);
      z7_ff     <= z6_ff;
      neg7_ff   <= neg6_ff;
      env7_ff   <= env6_ff;

      sine8_ff  <= neg7_ff ? -signed'(y_cap) : signed'(y_cap);
      env8_ff   <= env7_ff;

      se9_ff    <= sine_ext * env_ext;
      m10_ff    <= MIX_BITS'(se9_ff) * GAIN_S;

      acc_ff    <= acc_in;
      if (cmd.load_out) begin
         sample_ff <= sample_in;
      end
   end

endmodule
`default_nettype wire

// ----- tb/sine_mix_checker.sv -----
`default_nettype none
module sine_mix_checker
   import lsvb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic                     req_cmd,
   input  wire logic [NOTE_BITS-1:0]     req_note_number,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  wire logic                     csr_write_enable,
   input  wire logic [SCALE_BITS-1:0]    csr_write_data,
   output int                            failures,
   output int                            pending
);

   localparam int VOICES      = VOICES_DEFAULT;
   localparam int PHASE_BITS  = PHASE_BITS_DEFAULT;
   localparam int TABLE_DEPTH = SINE_TABLE_DEPTH_DEFAULT;

   localparam longint unsigned TOP_OCTAVE_HZ [NOTES_PER_OCTAVE] = '{
      14417920, 15275254, 16183568, 17145893, 18165441, 19245614,
      20390018, 21602472, 22887022, 24247955, 25689813, 27217408
   };

   logic [SCALE_BITS-1:0]            step_scale;
   logic [PHASE_BITS-1:0]            voice_phase [VOICES];
   logic [ENV_BITS-1:0]              voice_level [VOICES];
   logic [PITCH_BITS-1:0]            voice_pitch [VOICES];
   logic [VOICES-1:0]                voice_on;
   logic signed [SAMPLE_BITS-1:0]    expected_samples [$];
   int                               mismatch_count = 0;

   assign failures = mismatch_count;
   assign pending  = expected_samples.size();

   function automatic longint unsigned pitch_freq(input logic [PITCH_BITS-1:0] idx);
      longint unsigned clamped;
      longint unsigned gap;
      clamped = (idx > PITCH_TOP) ? PITCH_TOP : idx;
      gap = PITCH_TOP - clamped;
      return TOP_OCTAVE_HZ[NOTES_PER_OCTAVE - 1 - gap % NOTES_PER_OCTAVE]
             >> (gap / NOTES_PER_OCTAVE);
   endfunction

   function automatic longint unsigned quarter_wave(input longint unsigned z);
      longint unsigned z2;
      longint unsigned t1;
      longint unsigned t2;
      longint unsigned y;
      z2 = (z * z) >> 15;
      t1 = POLY_C1 - ((z2 * POLY_C2) >> 15);
      t2 = POLY_C0 - ((z2 * t1) >> 15);
      y  = (z * t2) >> 15;
      return (y > Q15_MAX) ? Q15_MAX : y;
   endfunction

   function automatic longint sine_at(input longint unsigned point);
      longint unsigned u;
      longint unsigned quad;
      longint unsigned z;
      longint          mag;
      u    = ((point * 65536) / TABLE_DEPTH) & 64'hFFFF;
      quad = u >> 14;
      z    = (u & 64'h3FFF) << 1;
      if (quad == 1 || quad == 3) z = Q15_ONE - z;
      mag = longint'(quarter_wave(z));
      return (quad >= 2) ? -mag : mag;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] advance_voices();
      longint          acc;
      longint          res;
      longint unsigned step;
      longint unsigned ph;
      longint unsigned env;
      longint unsigned mag;
      acc = 0;
      for (int i = 0; i < VOICES; i++) begin
         if (voice_on[i]) begin
            step = (pitch_freq(voice_pitch[i]) * longint'(step_scale))
                   >> (STEP_TOP - PHASE_BITS);
            ph = (longint'(voice_phase[i]) + step) & ((64'd1 << PHASE_BITS) - 1);
            voice_phase[i] = ph[PHASE_BITS-1:0];
            env = longint'(voice_level[i]) + ENV_RISE;
            if (env > ENV_FULL) env = ENV_FULL;
            voice_level[i] = env[ENV_BITS-1:0];
            acc += sine_at((ph * TABLE_DEPTH) >> PHASE_BITS) * longint'(env) * MIX_GAIN;
         end
      end
      if (acc < 0) begin
         mag = (longint'(-acc) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
         res = -longint'(mag);
      end else begin
         mag = (longint'(acc) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
         res = longint'(mag);
      end
      if (res > Q15_MAX) res = Q15_MAX;
      if (res < -Q15_ONE) res = -Q15_ONE;
      return res[SAMPLE_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] want;
      if (reset) begin
         step_scale = SCALE_RESET;
         voice_on   = '0;
         for (int i = 0; i < VOICES; i++) begin
            voice_phase[i] = '0;
            voice_level[i] = '0;
            voice_pitch[i] = '0;
         end
         expected_samples.delete();
      end else begin
         if (csr_write_enable) step_scale = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample_out: expected none, actual %0d", rsp_sample_out);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  $error("sample_out: expected %0d, actual %0d", want, rsp_sample_out);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_NOTE_ON) begin
               for (int i = 0; i < VOICES; i++) begin
                  voice_on[i]    = 1'b1;
                  voice_pitch[i] = PITCH_BITS'(req_note_number) + PITCH_BITS'(i);
                  voice_phase[i] = '0;
                  voice_level[i] = '0;
               end
            end else begin
               expected_samples.push_back(advance_voices());
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- tb/layered_sine_voice_bank_tb.sv -----
`default_nettype none
module layered_sine_voice_bank_tb;
   import lsvb_pkg::*;

   localparam int              WATCHDOG_LIMIT = 4000;
   localparam int              SETTLE_CYCLES  = 40;
   localparam logic [SCALE_BITS-1:0] SCALE_LOW  = 26'd1431655;
   localparam logic [SCALE_BITS-1:0] SCALE_HIGH = 26'd34359738;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_cmd          = CMD_TICK;
   logic [NOTE_BITS-1:0]          req_note_number  = '0;
   logic                          rsp_ready        = 1'b0;
   logic                          csr_write_enable = 1'b0;
   logic [SCALE_BITS-1:0]         csr_write_data   = '0;
   wire logic                     req_ready;
   wire logic                     rsp_valid;
   wire logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   int                            failures;
   int                            pending;
   int                            quiet_cycles = 0;
   bit                            calm = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   layered_sine_voice_bank u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_note_number  (req_note_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sine_mix_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_note_number  (req_note_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("layered_sine_voice_bank: mismatch");
         $finish;
      end
   end

   task automatic send_word(input logic cmd, input logic [NOTE_BITS-1:0] note);
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 11);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_note_number <= note;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every sample is back and the pipeline is quiet
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic [SCALE_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic play_note(input int ticks);
      send_word(CMD_NOTE_ON, NOTE_BITS'($urandom_range(127)));
      repeat (ticks) send_word(CMD_TICK, NOTE_BITS'($urandom_range(127)));
   endtask

   task automatic play_phase(input int words);
      int sent;
      int ticks;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(99) < 80) begin
            ticks = $urandom_range(40, 1);
            play_note(ticks);
            sent += ticks + 1;
         end else begin
            send_word(logic'($urandom_range(1)), NOTE_BITS'($urandom_range(127)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_word(CMD_TICK, 7'h7F);
      send_word(CMD_TICK, 7'h00);
      send_word(CMD_NOTE_ON, 7'h00);
      repeat (4) send_word(CMD_TICK, 7'h00);
      send_word(CMD_NOTE_ON, 7'h7F);
      repeat (4) send_word(CMD_TICK, 7'h7F);
      send_word(CMD_NOTE_ON, 7'd69);
      repeat (3) send_word(CMD_TICK, 7'h55);
      send_word(CMD_NOTE_ON, 7'h55);
      send_word(CMD_TICK, 7'h2A);
      send_word(CMD_NOTE_ON, 7'h2A);
      repeat (3) send_word(CMD_TICK, 7'h2A);
      drain();

      write_scale(SCALE_LOW);
      play_phase(130);
      drain();
      write_scale(SCALE_HIGH);
      play_phase(130);
      drain();
      write_scale({SCALE_BITS{1'b1}});
      play_phase(130);
      drain();

      // run long enough for every envelope to reach full scale
      calm = 1'b1;
      write_scale(SCALE_BITS'($urandom_range(SCALE_HIGH, SCALE_LOW)));
      play_note(560);
      calm = 1'b0;
      drain();

      repeat (4) begin
         write_scale(SCALE_BITS'($urandom_range(SCALE_HIGH, SCALE_LOW)));
         play_phase(70);
         drain();
      end
      write_scale(SCALE_RESET);
      play_phase(100);
      drain();

      if (failures == 0 && pending == 0) begin
         $display("layered_sine_voice_bank: match");
      end else begin
         $display("layered_sine_voice_bank: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
